>>> rtl/positional_list_engine_defines.svh
// assertion macros used by the rtl
`ifndef POSITIONAL_LIST_ENGINE_DEFINES_SVH
`define POSITIONAL_LIST_ENGINE_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define PLE_CHECK(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// property on the cycle that follows the antecedent
`define PLE_CHECK_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/ple_pkg.sv
package ple_pkg;

   localparam int DEPTH = 16;
   localparam int VAL_W = 32;
   localparam int POS_W = 7;
   localparam int CMD_W = 3;
   localparam int ST_W  = 2;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int IDX_W = $clog2(DEPTH);

   typedef enum logic [CMD_W-1:0] {
      CMD_INS_FRONT = 3'd0,
      CMD_INS_BACK  = 3'd1,
      CMD_INS_AT    = 3'd2,
      CMD_DEL_FRONT = 3'd3,
      CMD_DEL_BACK  = 3'd4,
      CMD_DEL_AT    = 3'd5,
      CMD_DUMP      = 3'd6
   } cmd_type;

   typedef enum logic [ST_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_HOLD,
      OP_LOAD,
      OP_LEFT,
      OP_RIGHT,
      OP_HEAD
   } cell_op_type;

   typedef enum logic [1:0] {
      ROW_HOLD,
      ROW_INSERT,
      ROW_DELETE,
      ROW_ROTATE
   } row_mode_type;

   typedef enum logic {
      S_IDLE,
      S_DUMP
   } state_type;

endpackage

>>> rtl/ple_cell.sv
module ple_cell (
   input  logic                                clock,
   input  ple_pkg::cell_op_type                op,
   input  logic signed [ple_pkg::VAL_W-1:0]    ins_value,
   input  logic signed [ple_pkg::VAL_W-1:0]    left_value,
   input  logic signed [ple_pkg::VAL_W-1:0]    right_value,
   input  logic signed [ple_pkg::VAL_W-1:0]    head_value,
   output logic signed [ple_pkg::VAL_W-1:0]    cell_value
);
   import ple_pkg::*;

   logic signed [VAL_W-1:0] value_ff;
   logic signed [VAL_W-1:0] value_in;

   always_comb begin
      case (op)
         OP_LOAD:  value_in = ins_value;
         OP_LEFT:  value_in = left_value;
         OP_RIGHT: value_in = right_value;
         OP_HEAD:  value_in = head_value;
         default:  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign cell_value = value_ff;

endmodule

>>> rtl/positional_list_engine.sv
// rsp_valid rises in the cycle after acceptance; a dump first moves to S_DUMP, which loads its first result
// insert, delete and no-op each complete from S_IDLE, so one transaction per cycle while rsp_ready
// a dump of n entries starts with a move to S_DUMP, then the cell row rotates once per result
// after the last dump result is loaded the engine returns to S_IDLE and accepts again once the slot is free
// reset clears the entry count, the dump index, the control state and rsp_valid; cell contents stay undefined
module positional_list_engine (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ple_pkg::CMD_W-1:0]           req_cmd,
   input  logic [ple_pkg::POS_W-1:0]           req_position,
   input  logic signed [ple_pkg::VAL_W-1:0]    req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [ple_pkg::ST_W-1:0]            rsp_status,
   output logic signed [ple_pkg::VAL_W-1:0]    rsp_entry_value,
   output logic [ple_pkg::POS_W-1:0]           rsp_entry_index,
   output logic [ple_pkg::POS_W-1:0]           rsp_entry_count,
   output logic                                rsp_last
);
   import ple_pkg::*;

`include "positional_list_engine_defines.svh"

   state_type               state_ff, state_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        dump_idx_ff, dump_idx_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ST_W-1:0]         rsp_status_ff, rsp_status_in;
   logic signed [VAL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]        rsp_index_ff, rsp_index_in;
   logic [POS_W-1:0]        rsp_count_ff, rsp_count_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    slot_free;
   logic                    req_accept;
   logic [POS_W-1:0]        count_ext;
   logic [POS_W-1:0]        ins_pos;
   logic [POS_W-1:0]        del_pos;
   logic [POS_W-1:0]        del_pos_m1;
   logic                    ins_bad;
   logic                    del_bad;
   logic [CNT_W-1:0]        dump_next;
   logic                    dump_last;

   row_mode_type            row_mode;
   logic [POS_W-1:0]        row_pos;

   logic signed [VAL_W-1:0] cell_value [DEPTH];
   cell_op_type             cell_op    [DEPTH];

   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == S_IDLE) && slot_free;
   assign req_accept = req_valid && req_ready;

   assign count_ext  = POS_W'(count_ff);
   assign ins_pos    = (req_cmd == CMD_INS_FRONT) ? POS_W'(1) :
                       (req_cmd == CMD_INS_BACK)  ? count_ext + POS_W'(1) : req_position;
   assign del_pos    = (req_cmd == CMD_DEL_FRONT) ? POS_W'(1) :
                       (req_cmd == CMD_DEL_BACK)  ? count_ext : req_position;
   assign del_pos_m1 = del_pos - POS_W'(1);
   assign ins_bad    = (ins_pos == '0) || (ins_pos > count_ext + POS_W'(1));
   assign del_bad    = (del_pos == '0) || (del_pos > count_ext);
   assign dump_next  = CNT_W'(dump_idx_ff) + CNT_W'(1);
   assign dump_last  = (dump_next == count_ff);

   // cell row
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam logic [POS_W-1:0] POS_I = POS_W'(i + 1);
      logic signed [VAL_W-1:0] left_value;
      logic signed [VAL_W-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      always_comb begin
         case (row_mode)
            ROW_INSERT: begin
               if (POS_I > row_pos) begin
                  cell_op[i] = OP_LEFT;
               end else if (POS_I == row_pos) begin
                  cell_op[i] = OP_LOAD;
               end else begin
                  cell_op[i] = OP_HOLD;
               end
            end
            ROW_DELETE: begin
               if ((POS_I >= row_pos) && (i < DEPTH - 1)) begin
                  cell_op[i] = OP_RIGHT;
               end else begin
                  cell_op[i] = OP_HOLD;
               end
            end
            ROW_ROTATE: begin
               if (POS_I < count_ext) begin
                  cell_op[i] = OP_RIGHT;
               end else if (POS_I == count_ext) begin
                  cell_op[i] = OP_HEAD;
               end else begin
                  cell_op[i] = OP_HOLD;
               end
            end
            default: cell_op[i] = OP_HOLD;
         endcase
      end

      ple_cell u_cell (
         .clock       (clock),
         .op          (cell_op[i]),
         .ins_value   (req_value),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .cell_value  (cell_value[i])
      );
   end

   // control
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      dump_idx_in   = dump_idx_ff;
      row_mode      = ROW_HOLD;
      row_pos       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = '0;
               rsp_index_in  = '0;
               rsp_count_in  = count_ext;
               rsp_last_in   = 1'b1;
               case (req_cmd)
                  CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else if (ins_bad) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        row_mode     = ROW_INSERT;
                        row_pos      = ins_pos;
                        count_in     = count_ff + CNT_W'(1);
                        rsp_index_in = ins_pos;
                        rsp_count_in = count_ext + POS_W'(1);
                     end
                  end
                  CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else if (del_bad) begin
                        rsp_status_in = ST_RANGE;
                     end else begin
                        row_mode     = ROW_DELETE;
                        row_pos      = del_pos;
                        count_in     = count_ff - CNT_W'(1);
                        rsp_value_in = cell_value[del_pos_m1[IDX_W-1:0]];
                        rsp_index_in = del_pos;
                        rsp_count_in = count_ext - POS_W'(1);
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in     = S_DUMP;
                        dump_idx_in  = '0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DUMP: begin
            if (slot_free) begin
               row_mode      = ROW_ROTATE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_OK;
               rsp_value_in  = cell_value[0];
               rsp_index_in  = POS_W'(dump_next);
               rsp_count_in  = count_ext;
               rsp_last_in   = dump_last;
               dump_idx_in   = dump_next[IDX_W-1:0];
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         dump_idx_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         dump_idx_ff  <= dump_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_entry_index = rsp_index_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_last        = rsp_last_ff;

   `PLE_CHECK(a_count_bound, count_ff <= CNT_W'(DEPTH), "entry count above depth")
   `PLE_CHECK_NEXT(a_count_hold, !req_accept, $stable(count_ff), "count moved without transaction")
   `PLE_CHECK(a_dump_not_last, (state_ff == S_DUMP && rsp_valid_ff) |-> !rsp_last_ff, "early last")
   `PLE_CHECK(a_dump_idx, (state_ff == S_DUMP) |-> (CNT_W'(dump_idx_ff) < count_ff), "dump overrun")

endmodule
